// File: hw/rtl/dht_pkg.sv
// Shared constants, types and command/status structs of the double-hash table.
package dht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int KEY_W       = 31;
    localparam int CFG_W       = 7;
    localparam int COLL_W      = 7;
    localparam int CNT_W       = $clog2(KEY_W);
    localparam int PADDR_W     = 3;

    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(61);
    localparam logic [CFG_W-1:0] STEP_RESET = CFG_W'(59);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        REG_TABLE_SIZE   = 1'b0,
        REG_STEP_MODULUS = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_FOUND     = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_FULL      = 3'd3,
        STS_ZERO_KEY  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_KEY,
        ST_SETUP,
        ST_DIV_STEP,
        ST_READ,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic    load;
        logic    div_key;
        logic    setup;
        logic    div_step;
        logic    mem_rd;
        logic    advance;
        logic    wr;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic key_zero;
        logic is_search;
        logic key_div_last;
        logic step_div_last;
        logic hit;
        logic last_probe;
    } t_dp_sts;

endpackage

// File: hw/rtl/dht_cfg.sv
// Configuration registers on the APB-style port and effective size and step modulus.
module dht_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dht_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [dht_pkg::CFG_W-1:0]      o_size,
    output logic [dht_pkg::CFG_W-1:0]      o_modulus
);

    logic [dht_pkg::CFG_W-1:0] r_table_size;
    logic [dht_pkg::CFG_W-1:0] r_step_modulus;
    logic                      wr_en;
    dht_pkg::t_reg_idx         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = dht_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size   <= dht_pkg::SIZE_RESET;
            r_step_modulus <= dht_pkg::STEP_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                dht_pkg::REG_TABLE_SIZE:   r_table_size   <= pwdata[dht_pkg::CFG_W-1:0];
                dht_pkg::REG_STEP_MODULUS: r_step_modulus <= pwdata[dht_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            dht_pkg::REG_TABLE_SIZE:   prdata = {{(32-dht_pkg::CFG_W){1'b0}}, r_table_size};
            dht_pkg::REG_STEP_MODULUS: prdata = {{(32-dht_pkg::CFG_W){1'b0}}, r_step_modulus};
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        if (r_table_size == '0) begin
            o_size = dht_pkg::CFG_W'(1);
        end else if (r_table_size > dht_pkg::CFG_W'(dht_pkg::TABLE_DEPTH)) begin
            o_size = dht_pkg::CFG_W'(dht_pkg::TABLE_DEPTH);
        end else begin
            o_size = r_table_size;
        end
    end

    assign o_modulus = (r_step_modulus == '0) ? dht_pkg::CFG_W'(1) : r_step_modulus;

endmodule

// File: hw/rtl/dht_ctrl.sv
// Controller state machine sequencing remainder, probe and result steps.
module dht_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dht_pkg::t_dp_sts i_sts,
    output dht_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);

    dht_pkg::t_state r_state;
    dht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dht_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dht_pkg::ST_IDLE: begin
                if (i_start && !i_sts.key_zero) begin
                    n_state = dht_pkg::ST_DIV_KEY;
                end
            end
            dht_pkg::ST_DIV_KEY: begin
                if (i_sts.key_div_last) begin
                    n_state = dht_pkg::ST_SETUP;
                end
            end
            dht_pkg::ST_SETUP: begin
                n_state = i_sts.is_search ? dht_pkg::ST_READ : dht_pkg::ST_DIV_STEP;
            end
            dht_pkg::ST_DIV_STEP: begin
                if (i_sts.step_div_last) begin
                    n_state = dht_pkg::ST_READ;
                end
            end
            dht_pkg::ST_READ: begin
                n_state = dht_pkg::ST_CHECK;
            end
            dht_pkg::ST_CHECK: begin
                n_state = (i_sts.hit || i_sts.last_probe) ? dht_pkg::ST_IDLE : dht_pkg::ST_READ;
            end
            default: n_state = dht_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = dht_pkg::STS_INSERTED;
        unique case (r_state)
            dht_pkg::ST_IDLE: begin
                o_cmd.load   = i_start;
                o_cmd.finish = i_start && i_sts.key_zero;
                o_cmd.status = dht_pkg::STS_ZERO_KEY;
            end
            dht_pkg::ST_DIV_KEY:  o_cmd.div_key  = 1'b1;
            dht_pkg::ST_SETUP:    o_cmd.setup    = 1'b1;
            dht_pkg::ST_DIV_STEP: o_cmd.div_step = 1'b1;
            dht_pkg::ST_READ:     o_cmd.mem_rd   = 1'b1;
            dht_pkg::ST_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.wr     = !i_sts.is_search;
                    o_cmd.status = i_sts.is_search ? dht_pkg::STS_FOUND
                                                   : dht_pkg::STS_INSERTED;
                end else if (i_sts.last_probe) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_sts.is_search ? dht_pkg::STS_NOT_FOUND
                                                   : dht_pkg::STS_FULL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != dht_pkg::ST_IDLE);

    a_no_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cmd.load)
        else $error("item loaded while busy");

endmodule

// File: hw/rtl/dht_dp.sv
// Datapath: bit-serial remainders, probe position, slot memory and result registers.
module dht_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dht_pkg::t_dp_cmd               i_cmd,
    output dht_pkg::t_dp_sts               o_sts,
    input  logic                           i_opcode,
    input  logic [dht_pkg::KEY_W-1:0]      i_key,
    input  logic [dht_pkg::CFG_W-1:0]      i_size,
    input  logic [dht_pkg::CFG_W-1:0]      i_modulus,
    output logic                           o_valid,
    output logic [dht_pkg::ADDR_W-1:0]     o_slot_index,
    output logic [dht_pkg::COLL_W-1:0]     o_collision_count,
    output logic [2:0]                     o_status
);

    localparam int DEPTH = dht_pkg::TABLE_DEPTH;
    localparam int AW    = dht_pkg::ADDR_W;
    localparam int KW    = dht_pkg::KEY_W;
    localparam int CW    = dht_pkg::CFG_W;

    function automatic logic [CW-1:0] rem_step(input logic [CW-1:0] rem, input logic b,
                                               input logic [CW-1:0] div);
        logic [CW:0] t;
        t = {rem, b};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[CW-1:0];
    endfunction

    logic [KW-1:0]              mem [DEPTH];
    logic [DEPTH-1:0]           r_mem_vld;
    logic [KW-1:0]              r_rdata;
    logic                       r_rvld;

    logic [KW-1:0]              r_key;
    dht_pkg::t_opcode           r_op;
    logic [KW-1:0]              r_dividend;
    logic [CW-1:0]              r_rem_s;
    logic [CW-1:0]              r_rem_q;
    logic [CW-1:0]              r_rem_t;
    logic [dht_pkg::CNT_W-1:0]  r_cnt;
    logic [AW-1:0]              r_pos;
    logic [CW-1:0]              r_n;
    logic [dht_pkg::COLL_W-1:0] r_coll;

    logic                       r_out_vld;
    logic [AW-1:0]              r_out_slot;
    logic [dht_pkg::COLL_W-1:0] r_out_coll;
    dht_pkg::t_status           r_out_sts;

    logic [KW-1:0]              rdata_eff;
    logic [CW-1:0]              step_num;
    logic [CW:0]                ins_sum;
    logic [AW-1:0]              ins_next;
    logic [AW-1:0]              srch_next;
    logic                       is_search;

    assign is_search = (r_op == dht_pkg::OP_SEARCH);
    assign rdata_eff = r_rvld ? r_rdata : '0;
    assign step_num  = i_modulus - r_rem_q;

    always_comb begin
        ins_sum = {1'b0, CW'(r_pos)} + {1'b0, r_rem_t};
        if (ins_sum >= {1'b0, i_size}) begin
            ins_sum = ins_sum - {1'b0, i_size};
        end
        ins_next  = ins_sum[AW-1:0];
        srch_next = (CW'(r_pos) + CW'(1) == i_size) ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key      <= i_key;
            r_op       <= dht_pkg::t_opcode'(i_opcode);
            r_dividend <= i_key;
            r_rem_s    <= '0;
            r_rem_q    <= '0;
            r_cnt      <= '0;
        end else if (i_cmd.div_key) begin
            r_dividend <= {r_dividend[KW-2:0], 1'b0};
            r_rem_s    <= rem_step(r_rem_s, r_dividend[KW-1], i_size);
            r_rem_q    <= rem_step(r_rem_q, r_dividend[KW-1], i_modulus);
            r_cnt      <= r_cnt + 1'b1;
        end else if (i_cmd.setup) begin
            r_dividend <= {step_num, {(KW-CW){1'b0}}};
            r_rem_t    <= '0;
            r_cnt      <= '0;
            r_pos      <= r_rem_s[AW-1:0];
            r_n        <= '0;
            r_coll     <= '0;
        end else if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[KW-2:0], 1'b0};
            r_rem_t    <= rem_step(r_rem_t, r_dividend[KW-1], i_size);
            r_cnt      <= r_cnt + 1'b1;
        end else if (i_cmd.advance) begin
            r_pos      <= is_search ? srch_next : ins_next;
            r_n        <= r_n + 1'b1;
            r_coll     <= r_coll + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem[r_pos] <= r_key;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_rvld    <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_mem_vld[r_pos] <= 1'b1;
            end
            if (i_cmd.mem_rd) begin
                r_rvld <= r_mem_vld[r_pos];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_sts <= i_cmd.status;
            case (i_cmd.status)
                dht_pkg::STS_INSERTED: begin
                    r_out_slot <= r_pos;
                    r_out_coll <= r_coll;
                end
                dht_pkg::STS_FOUND: begin
                    r_out_slot <= r_pos;
                    r_out_coll <= '0;
                end
                default: begin
                    r_out_slot <= '0;
                    r_out_coll <= '0;
                end
            endcase
        end
    end

    assign o_sts.key_zero      = (i_key == '0);
    assign o_sts.is_search     = is_search;
    assign o_sts.key_div_last  = (r_cnt == dht_pkg::CNT_W'(KW - 1));
    assign o_sts.step_div_last = (r_cnt == dht_pkg::CNT_W'(CW - 1));
    assign o_sts.hit           = is_search ? (rdata_eff == r_key) : (rdata_eff == '0);
    assign o_sts.last_probe    = (r_n == i_size - 1'b1);

    assign o_valid           = r_out_vld;
    assign o_slot_index      = r_out_slot;
    assign o_collision_count = r_out_coll;
    assign o_status          = r_out_sts;

    a_write_empty_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (rdata_eff == '0))
        else $error("write to an occupied slot");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_rd |-> (CW'(r_pos) < i_size))
        else $error("probe beyond table size");

    a_result_follows_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> o_valid)
        else $error("result strobe missing");

endmodule

// File: hw/rtl/double_hash_table_insert_search.sv
// Top level of the double-hash table with insert and search.
// One item at a time: an item is taken when start is high and busy is low, and its
// result shows on the result ports for one cycle with o_valid, in the cycle after the
// last step. A zero key answers at once (result in the cycle after start). Otherwise
// the key remainders come first (one bit a cycle through the bit-serial remainder
// unit), then a setup step, then for insert the step remainder; each probe of the
// single-port slot memory is a read, then a compare. An operation makes at least one
// probe and at most as many probes as the table size. The slot store reads as empty
// after reset with no clearing pass; the receiver cannot stall results.
module double_hash_table_insert_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_opcode,
    input  logic [dht_pkg::KEY_W-1:0]          i_key,
    output logic                               o_valid,
    output logic [dht_pkg::ADDR_W-1:0]         o_slot_index,
    output logic [dht_pkg::COLL_W-1:0]         o_collision_count,
    output logic [2:0]                         o_status,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dht_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    dht_pkg::t_dp_cmd          cmd;
    dht_pkg::t_dp_sts          sts;
    logic [dht_pkg::CFG_W-1:0] size;
    logic [dht_pkg::CFG_W-1:0] modulus;

    dht_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_size    (size),
        .o_modulus (modulus)
    );

    dht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    dht_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_key             (i_key),
        .i_size            (size),
        .i_modulus         (modulus),
        .o_valid           (o_valid),
        .o_slot_index      (o_slot_index),
        .o_collision_count (o_collision_count),
        .o_status          (o_status)
    );

endmodule
